// ===== rtl/fma_pkg.sv =====
// ----------------------------------------------------------------------------
// Fit memory allocator package
// Shared constants, codes and transaction types of the segment allocator.
// ----------------------------------------------------------------------------
package fma_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int SIZE_BITS    = 16;
    localparam int OWNER_BITS   = 8;
    localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
    localparam int COUNT_BITS   = 5;
    localparam int STATUS_BITS  = 2;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [SIZE_BITS-1:0]  TOTAL_RESET = SIZE_BITS'(1024);

    localparam logic [STATUS_BITS-1:0] STATUS_GRANTED    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NO_FIT     = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_TABLE_FULL = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_FREED      = 2'd3;

    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_FREE     = 1'b1;

    localparam logic STRATEGY_FIRST_FIT = 1'b0;
    localparam logic STRATEGY_BEST_FIT  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_TOTAL_SIZE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRATEGY   = 2'd1;

    typedef struct packed {
        logic                  operation;
        logic [OWNER_BITS-1:0] owner_id;
        logic [SIZE_BITS-1:0]  request_size;
    } t_in;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [SIZE_BITS-1:0]   block_start;
        logic [SIZE_BITS-1:0]   block_size;
        logic [COUNT_BITS-1:0]  freed_count;
    } t_out;

    typedef struct packed {
        logic [SIZE_BITS-1:0]  start;
        logic [SIZE_BITS-1:0]  length;
        logic                  busy;
        logic [OWNER_BITS-1:0] owner;
    } t_seg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_SPLIT,
        S_GRANT,
        S_FREE,
        S_MERGE_LOAD,
        S_MERGE,
        S_MERGE_END,
        S_DONE
    } t_state;

endpackage

// ===== rtl/fma_alu.sv =====
// ----------------------------------------------------------------------------
// Fit memory allocator arithmetic unit
// Shared add/subtract unit; the top bit is the carry or the borrow.
// ----------------------------------------------------------------------------
module fma_alu (
    input  logic [fma_pkg::SIZE_BITS-1:0] i_a,
    input  logic [fma_pkg::SIZE_BITS-1:0] i_b,
    input  logic                          i_sub,
    output logic [fma_pkg::SIZE_BITS:0]   o_result
);
    import fma_pkg::*;

    always_comb begin
        if (i_sub) begin
            o_result = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            o_result = {1'b0, i_a} + {1'b0, i_b};
        end
    end

endmodule

// ===== rtl/fma_seg_table.sv =====
// ----------------------------------------------------------------------------
// Fit memory allocator segment table
// Segment storage with one read port and one write port.
// ----------------------------------------------------------------------------
module fma_seg_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_init,
    input  logic [fma_pkg::SIZE_BITS-1:0] i_init_len,
    input  logic [fma_pkg::IDX_BITS-1:0]  i_rd_idx,
    output fma_pkg::t_seg                 o_rd,
    input  logic                          i_we,
    input  logic [fma_pkg::IDX_BITS-1:0]  i_wr_idx,
    input  fma_pkg::t_seg                 i_wr
);
    import fma_pkg::*;

    logic [SIZE_BITS-1:0]  r_start  [MAX_SEGMENTS];
    logic [SIZE_BITS-1:0]  r_length [MAX_SEGMENTS];
    logic                  r_busy   [MAX_SEGMENTS];
    logic [OWNER_BITS-1:0] r_owner  [MAX_SEGMENTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start[0]  <= '0;
            r_length[0] <= TOTAL_RESET;
            r_busy[0]   <= 1'b0;
        end else if (i_init) begin
            r_start[0]  <= '0;
            r_length[0] <= i_init_len;
            r_busy[0]   <= 1'b0;
        end else if (i_we) begin
            r_start[i_wr_idx]  <= i_wr.start;
            r_length[i_wr_idx] <= i_wr.length;
            r_busy[i_wr_idx]   <= i_wr.busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_owner[i_wr_idx] <= i_wr.owner;
        end
    end

    assign o_rd.start  = r_start[i_rd_idx];
    assign o_rd.length = r_length[i_rd_idx];
    assign o_rd.busy   = r_busy[i_rd_idx];
    assign o_rd.owner  = r_owner[i_rd_idx];

endmodule

// ===== rtl/fit_memory_allocator.sv =====
// ----------------------------------------------------------------------------
// Fit memory allocator
// First-fit or best-fit segment allocator over an address-ordered table.
// ----------------------------------------------------------------------------
// One transaction is handled at a time, and the input stalls until its result
// is loaded into the output register. An allocation scans the table and, when
// a split is needed, shifts it one entry per cycle through its single read
// and write port. A free makes one pass to release the owner's segments
// and one pass to merge free neighbours. A zero-size allocation gives a
// no fit result without scanning the table.
module fit_memory_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  fma_pkg::t_in                     i_in_data,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output fma_pkg::t_out                    o_out_data,
    input  logic                             i_out_stall,
    input  logic                             i_cfg_we,
    input  logic [fma_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [fma_pkg::SIZE_BITS-1:0]    i_cfg_data
);
    import fma_pkg::*;

    t_state                r_state, n_state;
    logic [IDX_BITS-1:0]   r_idx, n_idx;
    logic [IDX_BITS-1:0]   r_wr, n_wr;
    logic [IDX_BITS-1:0]   r_pick, n_pick;
    logic                  r_found, n_found;
    logic [SIZE_BITS-1:0]  r_best, n_best;
    logic [SIZE_BITS-1:0]  r_req, n_req;
    logic [OWNER_BITS-1:0] r_owner, n_owner;
    logic [COUNT_BITS-1:0] r_freed, n_freed;
    logic [COUNT_BITS-1:0] r_count, n_count;
    t_seg                  r_hold, n_hold;
    t_out                  r_res, n_res;
    t_out                  r_out;
    logic                  r_out_valid;
    logic [SIZE_BITS-1:0]  r_total;
    logic                  r_strategy;

    logic                  tbl_init;
    logic [IDX_BITS-1:0]   rd_idx;
    t_seg                  rd_seg;
    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_idx;
    t_seg                  wr_seg;
    logic [SIZE_BITS-1:0]  alu_a, alu_b;
    logic                  alu_sub;
    logic [SIZE_BITS:0]    alu_res;
    logic                  last;
    logic                  fits;
    logic                  out_load;

    assign tbl_init = i_cfg_we && (i_cfg_index == REG_TOTAL_SIZE);

    fma_seg_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_init     (tbl_init),
        .i_init_len (i_cfg_data),
        .i_rd_idx   (rd_idx),
        .o_rd       (rd_seg),
        .i_we       (wr_en),
        .i_wr_idx   (wr_idx),
        .i_wr       (wr_seg)
    );

    fma_alu u_alu (
        .i_a      (alu_a),
        .i_b      (alu_b),
        .i_sub    (alu_sub),
        .o_result (alu_res)
    );

    assign last     = ({1'b0, r_idx} == (r_count - COUNT_BITS'(1)));
    assign fits     = !rd_seg.busy && !alu_res[SIZE_BITS];
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_wr    = r_wr;
        n_pick  = r_pick;
        n_found = r_found;
        n_best  = r_best;
        n_req   = r_req;
        n_owner = r_owner;
        n_freed = r_freed;
        n_count = r_count;
        n_hold  = r_hold;
        n_res   = r_res;
        rd_idx  = r_idx;
        wr_en   = 1'b0;
        wr_idx  = r_idx;
        wr_seg  = rd_seg;
        alu_a   = rd_seg.length;
        alu_b   = r_req;
        alu_sub = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data.request_size;
                    n_owner = i_in_data.owner_id;
                    n_idx   = '0;
                    n_freed = '0;
                    n_found = 1'b0;
                    if (i_in_data.operation == OP_FREE) begin
                        n_state = S_FREE;
                    end else if (i_in_data.request_size == '0) begin
                        n_res   = '{STATUS_NO_FIT, '0, '0, '0};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (fits && (!r_found || (r_strategy == STRATEGY_BEST_FIT &&
                        alu_res[SIZE_BITS-1:0] < r_best))) begin
                    n_found = 1'b1;
                    n_pick  = r_idx;
                    n_best  = alu_res[SIZE_BITS-1:0];
                end
                if (last || (fits && r_strategy == STRATEGY_FIRST_FIT)) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx = r_idx + IDX_BITS'(1);
                end
            end
            S_DECIDE: begin
                if (!r_found) begin
                    n_res   = '{STATUS_NO_FIT, '0, '0, '0};
                    n_state = S_DONE;
                end else if (r_best == '0) begin
                    n_state = S_GRANT;
                end else if (r_count == COUNT_BITS'(MAX_SEGMENTS)) begin
                    n_res   = '{STATUS_TABLE_FULL, '0, '0, '0};
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_count[IDX_BITS-1:0];
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (r_idx == r_pick + IDX_BITS'(1)) begin
                    n_state = S_SPLIT;
                end else begin
                    rd_idx = r_idx - IDX_BITS'(1);
                    wr_en  = 1'b1;
                    wr_idx = r_idx;
                    wr_seg = rd_seg;
                    n_idx  = r_idx - IDX_BITS'(1);
                end
            end
            S_SPLIT: begin
                rd_idx  = r_pick;
                alu_a   = rd_seg.start;
                alu_b   = r_req;
                alu_sub = 1'b0;
                wr_en   = 1'b1;
                wr_idx  = r_pick + IDX_BITS'(1);
                wr_seg  = '{alu_res[SIZE_BITS-1:0], r_best, 1'b0, '0};
                n_count = r_count + COUNT_BITS'(1);
                n_state = S_GRANT;
            end
            S_GRANT: begin
                rd_idx  = r_pick;
                wr_en   = 1'b1;
                wr_idx  = r_pick;
                wr_seg  = '{rd_seg.start, r_req, 1'b1, r_owner};
                n_res   = '{STATUS_GRANTED, rd_seg.start, r_req, '0};
                n_state = S_DONE;
            end
            S_FREE: begin
                if (rd_seg.busy && rd_seg.owner == r_owner) begin
                    wr_en   = 1'b1;
                    wr_idx  = r_idx;
                    wr_seg  = '{rd_seg.start, rd_seg.length, 1'b0, rd_seg.owner};
                    n_freed = r_freed + COUNT_BITS'(1);
                end
                if (last) begin
                    n_state = S_MERGE_LOAD;
                end else begin
                    n_idx = r_idx + IDX_BITS'(1);
                end
            end
            S_MERGE_LOAD: begin
                rd_idx = '0;
                n_hold = rd_seg;
                n_wr   = '0;
                n_idx  = IDX_BITS'(1);
                if (r_count == COUNT_BITS'(1)) begin
                    n_state = S_MERGE_END;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (!r_hold.busy && !rd_seg.busy) begin
                    alu_a         = r_hold.length;
                    alu_b         = rd_seg.length;
                    alu_sub       = 1'b0;
                    n_hold.length = alu_res[SIZE_BITS-1:0];
                end else begin
                    wr_en  = 1'b1;
                    wr_idx = r_wr;
                    wr_seg = r_hold;
                    n_wr   = r_wr + IDX_BITS'(1);
                    n_hold = rd_seg;
                end
                if (last) begin
                    n_state = S_MERGE_END;
                end else begin
                    n_idx = r_idx + IDX_BITS'(1);
                end
            end
            S_MERGE_END: begin
                wr_en   = 1'b1;
                wr_idx  = r_wr;
                wr_seg  = r_hold;
                n_count = {1'b0, r_wr} + COUNT_BITS'(1);
                n_res   = '{STATUS_FREED, '0, '0, r_freed};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= COUNT_BITS'(1);
        end else begin
            r_state <= n_state;
            r_count <= tbl_init ? COUNT_BITS'(1) : n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_wr    <= n_wr;
        r_pick  <= n_pick;
        r_found <= n_found;
        r_best  <= n_best;
        r_req   <= n_req;
        r_owner <= n_owner;
        r_freed <= n_freed;
        r_hold  <= n_hold;
        r_res   <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= TOTAL_RESET;
            r_strategy <= STRATEGY_FIRST_FIT;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_TOTAL_SIZE) begin
                r_total <= i_cfg_data;
            end else if (i_cfg_index == REG_STRATEGY) begin
                r_strategy <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The table always holds at least one segment and never more than its depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= COUNT_BITS'(MAX_SEGMENTS)))
        else $error("segment count out of range");

    // Once a transaction is taken, the input stalls until its result is out.
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a transaction is in progress");

    // A granted block is never empty.
    a_grant_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == STATUS_GRANTED) |->
        (o_out_data.block_size != '0))
        else $error("granted block of zero size");

    // A total size write sets the total size and resets the table to one segment.
    a_total_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_init |=> (r_total == $past(i_cfg_data)) && (r_count == COUNT_BITS'(1)))
        else $error("table not reinitialised on a total size write");

endmodule

// ===== bench/alloc_check_pkg.sv =====
// ----------------------------------------------------------------------------
// Allocator result ledger
// Keeps a behavioural copy of the segment table and the two registers. Each
// accepted request is applied to this copy to give the expected result, and
// each result from the block is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
package alloc_check_pkg;

    import fma_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED_HI = 2'd3;
    localparam int SHOWN_MISMATCHES = 100;

    class allocation_ledger;

        t_seg                 segs [MAX_SEGMENTS];
        logic                 seg_live [MAX_SEGMENTS];
        logic [SIZE_BITS-1:0] managed_size;
        logic                 placement;
        t_out                 expected_outcomes [$];
        int                   failures;
        int                   granted;
        int                   no_fit;
        int                   table_full;
        int                   frees_seen;

        function new();
            managed_size = TOTAL_RESET;
            placement    = STRATEGY_FIRST_FIT;
            failures     = 0;
            granted      = 0;
            no_fit       = 0;
            table_full   = 0;
            frees_seen   = 0;
            clear_table();
        endfunction

        function void clear_table();
            for (int i = 0; i < MAX_SEGMENTS; i++) begin
                segs[i]     = '0;
                seg_live[i] = 1'b0;
            end
            seg_live[0]    = 1'b1;
            segs[0].length = managed_size;
        endfunction

        function int live_count();
            int n;
            n = 0;
            while (n < MAX_SEGMENTS && seg_live[n])
                n++;
            return n;
        endfunction

        function void shift_entry(int dst, int src);
            segs[dst]     = segs[src];
            seg_live[dst] = seg_live[src];
        endfunction

        function void coalesce();
            int n;
            int i;
            n = live_count();
            i = 0;
            while (i + 1 < n) begin
                if (!segs[i].busy && !segs[i + 1].busy) begin
                    segs[i].length = segs[i].length + segs[i + 1].length;
                    for (int k = i + 1; k + 1 < n; k++)
                        shift_entry(k, k + 1);
                    segs[n - 1]     = '0;
                    seg_live[n - 1] = 1'b0;
                    n--;
                end else begin
                    i++;
                end
            end
        endfunction

        function void write_register(logic [CFG_IDX_BITS-1:0] idx,
                                     logic [SIZE_BITS-1:0] value);
            case (idx)
                REG_TOTAL_SIZE: begin
                    managed_size = value;
                    clear_table();
                end
                REG_STRATEGY: begin
                    placement = value[0];
                end
                default: begin
                end
            endcase
        endfunction

        function t_out predict_outcome(t_in req);
            t_out                 res;
            int                   n;
            int                   pick;
            logic                 found;
            logic [SIZE_BITS-1:0] best;
            logic [SIZE_BITS-1:0] waste;
            res        = '0;
            res.status = STATUS_NO_FIT;
            n          = live_count();
            found      = 1'b0;
            pick       = 0;
            best       = '0;
            if (req.operation == OP_FREE) begin
                for (int i = 0; i < n; i++) begin
                    if (segs[i].busy && segs[i].owner == req.owner_id) begin
                        segs[i].busy    = 1'b0;
                        res.freed_count = res.freed_count + 1'b1;
                    end
                end
                coalesce();
                res.status = STATUS_FREED;
            end else if (req.request_size != '0) begin
                for (int i = 0; i < n; i++) begin
                    if (!segs[i].busy && segs[i].length >= req.request_size) begin
                        waste = segs[i].length - req.request_size;
                        if (!found || (placement == STRATEGY_BEST_FIT && waste < best)) begin
                            found = 1'b1;
                            pick  = i;
                            best  = waste;
                        end
                    end
                end
                if (!found) begin
                    res.status = STATUS_NO_FIT;
                end else if (segs[pick].length > req.request_size && n >= MAX_SEGMENTS) begin
                    res.status = STATUS_TABLE_FULL;
                end else begin
                    if (segs[pick].length > req.request_size) begin
                        for (int k = n; k > pick + 1; k--)
                            shift_entry(k, k - 1);
                        seg_live[pick + 1]    = 1'b1;
                        segs[pick + 1].busy   = 1'b0;
                        segs[pick + 1].owner  = '0;
                        segs[pick + 1].start  = segs[pick].start + req.request_size;
                        segs[pick + 1].length = segs[pick].length - req.request_size;
                        segs[pick].length     = req.request_size;
                    end
                    segs[pick].busy  = 1'b1;
                    segs[pick].owner = req.owner_id;
                    res.status       = STATUS_GRANTED;
                    res.block_start  = segs[pick].start;
                    res.block_size   = segs[pick].length;
                end
            end
            return res;
        endfunction

        function void log_request(t_in req);
            t_out res;
            res = predict_outcome(req);
            case (res.status)
                STATUS_GRANTED:    granted++;
                STATUS_NO_FIT:     no_fit++;
                STATUS_TABLE_FULL: table_full++;
                default:           frees_seen++;
            endcase
            expected_outcomes = {expected_outcomes, res};
        endfunction

        function void note_failure();
            failures++;
            if (failures == SHOWN_MISMATCHES)
                $display("%0t: further mismatches are counted but not shown", $time);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                if (failures < SHOWN_MISMATCHES)
                    $display("%0t: %s mismatch: expected %0d, actual %0d",
                             $time, field, want, got);
                note_failure();
            end
        endfunction

        function void match_result(t_out got);
            t_out want;
            if (expected_outcomes.size() == 0) begin
                if (failures < SHOWN_MISMATCHES)
                    $display("%0t: unexpected result: expected none, actual %h", $time, got);
                note_failure();
                return;
            end
            want = expected_outcomes.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("block_start", 32'(want.block_start), 32'(got.block_start));
            compare_field("block_size", 32'(want.block_size), 32'(got.block_size));
            compare_field("freed_count", 32'(want.freed_count), 32'(got.freed_count));
        endfunction

        function logic [SIZE_BITS-1:0] some_free_length();
            logic [SIZE_BITS-1:0] lengths [$];
            int                   n;
            n = live_count();
            for (int i = 0; i < n; i++) begin
                if (!segs[i].busy && segs[i].length != '0)
                    lengths = {lengths, segs[i].length};
            end
            if (lengths.size() == 0)
                return '0;
            return lengths[$urandom_range(0, lengths.size() - 1)];
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        function void close_out();
            if (expected_outcomes.size() != 0) begin
                $display("%0t: %0d expected results never arrived",
                         $time, expected_outcomes.size());
                failures++;
            end
        endfunction

    endclass

endpackage

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Fit memory allocator testbench
// Drives allocate and free transactions through short directed sequences and
// then random phases under several memory sizes and both placement rules,
// with random gaps and stalls and long receiver hold-offs. Every result is
// checked against a behavioural copy of the segment table.
// ----------------------------------------------------------------------------
module testbench;

    import fma_pkg::*;
    import alloc_check_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 200;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    in_valid;
    t_in                     in_data;
    logic                    in_stall;
    logic                    out_valid;
    t_out                    out_data;
    logic                    out_stall;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [SIZE_BITS-1:0]    cfg_data;

    allocation_ledger ledger;
    int               requests_taken = 0;
    int unsigned      cycle_count = 0;
    int               holds_done = 0;

    fit_memory_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !in_stall) begin
                ledger.log_request(in_data);
                requests_taken++;
            end
            if (out_valid && !out_stall)
                ledger.match_result(out_data);
        end
    end

    function automatic bit calm_stretch();
        return requests_taken >= 950 && requests_taken < 1150;
    endfunction

    initial begin
        int hold_left;
        int next_hold;
        hold_left = 0;
        next_hold = 600;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && requests_taken >= next_hold) begin
                hold_left = HOLD_CYCLES;
                next_hold = next_hold + 700;
                holds_done++;
            end
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = !calm_stretch() && ($urandom_range(0, 99) < 20);
            end
        end
    end

    task automatic send_item(input logic op, input logic [OWNER_BITS-1:0] owner,
                             input logic [SIZE_BITS-1:0] size);
        while (!calm_stretch() && $urandom_range(0, 99) < 20) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid              = 1'b1;
        in_data.operation     = op;
        in_data.owner_id      = owner;
        in_data.request_size  = size;
        do
            @(posedge i_clk);
        while (in_stall);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [SIZE_BITS-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        ledger.write_register(idx, value);
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (ledger.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        logic [OWNER_BITS-1:0] owners [8];
        logic [SIZE_BITS-1:0]  phase_total [PHASES];
        logic                  phase_rule [PHASES];
        logic [OWNER_BITS-1:0] who;
        logic [SIZE_BITS-1:0]  req_len;
        int                    span_cap;
        int                    pick;

        ledger    = new();
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_TOTAL_SIZE;
        cfg_data  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset layout: zero, oversize and unit requests, an exact fit of the
        // remainder, one with no room, an unmatched free, merging frees.
        send_item(OP_ALLOCATE, 8'h00, 16'd0);
        send_item(OP_ALLOCATE, 8'hFF, 16'hFFFF);
        send_item(OP_ALLOCATE, 8'h00, 16'd1);
        send_item(OP_ALLOCATE, 8'hFF, 16'd1023);
        send_item(OP_ALLOCATE, 8'h12, 16'd1);
        send_item(OP_FREE, 8'h5A, 16'hFFFF);
        send_item(OP_FREE, 8'h00, 16'd0);
        send_item(OP_FREE, 8'hFF, 16'd0);
        wait_drained();

        // Best fit must skip the first large hole for the tighter one.
        write_register(REG_STRATEGY, SIZE_BITS'(STRATEGY_BEST_FIT));
        send_item(OP_ALLOCATE, 8'h01, 16'd300);
        send_item(OP_ALLOCATE, 8'h02, 16'd50);
        send_item(OP_ALLOCATE, 8'h01, 16'd100);
        send_item(OP_ALLOCATE, 8'h02, 16'd30);
        send_item(OP_FREE, 8'h01, 16'd0);
        send_item(OP_ALLOCATE, 8'h03, 16'd90);
        wait_drained();

        // Fill the table, then a split is refused and an exact fit is not.
        write_register(REG_TOTAL_SIZE, 16'd17);
        write_register(REG_STRATEGY, SIZE_BITS'(STRATEGY_FIRST_FIT));
        write_register(REG_UNMAPPED_LO, 16'hA5A5);
        for (int k = 0; k < MAX_SEGMENTS - 1; k++)
            send_item(OP_ALLOCATE, OWNER_BITS'(k * 17), 16'd1);
        send_item(OP_ALLOCATE, 8'h33, 16'd1);
        send_item(OP_ALLOCATE, 8'hCC, 16'd2);
        wait_drained();

        phase_total[0] = 16'd1024;
        phase_total[1] = 16'hFFFF;
        phase_total[2] = 16'd1;
        phase_total[3] = 16'd0;
        phase_total[4] = SIZE_BITS'($urandom_range(16, 2000));
        phase_total[5] = SIZE_BITS'($urandom);
        phase_total[6] = 16'd300;
        phase_total[7] = 16'd4096;
        for (int p = 0; p < PHASES; p++)
            phase_rule[p] = (p % 2 == 1 || p == 6) ? STRATEGY_BEST_FIT : STRATEGY_FIRST_FIT;

        for (int p = 0; p < PHASES; p++) begin
            write_register(REG_UNMAPPED_HI, SIZE_BITS'($urandom));
            write_register(REG_TOTAL_SIZE, phase_total[p]);
            write_register(REG_STRATEGY, SIZE_BITS'(phase_rule[p]));
            owners[0] = '0;
            owners[7] = '1;
            for (int k = 1; k < 7; k++)
                owners[k] = OWNER_BITS'($urandom);
            span_cap = (phase_total[p] > 5) ? phase_total[p] / 5 : 1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                who  = owners[$urandom_range(0, 7)];
                if (pick < 22) begin
                    send_item(OP_FREE, who, SIZE_BITS'($urandom));
                end else if (pick < 25) begin
                    send_item(OP_FREE, OWNER_BITS'($urandom), SIZE_BITS'($urandom));
                end else if (pick < 37) begin
                    req_len = ledger.some_free_length();
                    if (req_len == '0)
                        req_len = 16'd1;
                    send_item(OP_ALLOCATE, who, req_len);
                end else if (pick < 44) begin
                    req_len = ($urandom_range(0, 3) == 0) ? {SIZE_BITS{1'b0}}
                                                          : SIZE_BITS'($urandom);
                    send_item(OP_ALLOCATE, OWNER_BITS'($urandom), req_len);
                end else begin
                    send_item(OP_ALLOCATE, who, SIZE_BITS'($urandom_range(1, span_cap)));
                end
            end
            wait_drained();
        end

        repeat (40) @(negedge i_clk);
        ledger.close_out();
        $display("Ran %0d requests over %0d register settings: %0d granted, %0d no fit,",
                 requests_taken, PHASES + 3, ledger.granted, ledger.no_fit);
        $display("%0d refused on a full table, %0d frees, %0d long receiver hold-offs.",
                 ledger.table_full, ledger.frees_seen, holds_done);
        if (ledger.failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/fma_pkg.sv
rtl/fma_alu.sv
rtl/fma_seg_table.sv
rtl/fit_memory_allocator.sv
bench/alloc_check_pkg.sv
bench/testbench.sv
